// File: rtl/zvpt_pkg.sv
// ----------------------------------------------------------------------------
// zvpt_pkg - zero value predictor table shared definitions
// Table geometry, entry layout, codes and small helper functions.
// ----------------------------------------------------------------------------
package zvpt_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int COUNT_WIDTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CLR_W       = ADDR_W + 1;

    // Field widths of the streams
    localparam int VALUE_W   = 64;
    localparam int KIND_W    = 2;
    localparam int BASE_W    = 13;
    localparam int OFFSET_W  = 12;
    localparam int ENTRY_W   = 12;
    localparam int OUT_CNT_W = 32;
    localparam int SUM_W     = BASE_W + 1;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 112;

    // Value kinds
    localparam logic [KIND_W-1:0] KIND_INT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_F32     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_F64     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    // Result status
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Base index that marks an item to be dropped
    localparam logic [BASE_W-1:0] BASE_SKIP = '1;

    typedef struct packed {
        logic [1:0]             pred;
        logic [KIND_W-1:0]      kind;
        logic [COUNT_WIDTH-1:0] total;
        logic [COUNT_WIDTH-1:0] zeros;
        logic [COUNT_WIDTH-1:0] hits;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    localparam entry_t ENTRY_RESET = '{
        pred:  2'd0,
        kind:  KIND_UNKNOWN,
        total: '0,
        zeros: '0,
        hits:  '0
    };

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + COUNT_WIDTH'(1);
    endfunction

    // Clamp a counter to the 32-bit output field
    function automatic logic [OUT_CNT_W-1:0] out_count(input logic [COUNT_WIDTH-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return (|w[63:32]) ? '1 : w[31:0];
    endfunction

    // Plus and minus zero both count as zero for floats
    function automatic logic tests_zero(input logic [VALUE_W-1:0] v,
                                        input logic [KIND_W-1:0]  kind);
        logic z;
        case (kind)
            KIND_F32: z = (v[30:0] == '0);
            KIND_F64: z = (v[62:0] == '0);
            default:  z = (v == '0);
        endcase
        return z;
    endfunction

endpackage

// File: rtl/zero_value_predictor_table_core.sv
// ----------------------------------------------------------------------------
// zero_value_predictor_table_core - per-load zero value predictor table
// Tracks, per load site, how often the loaded value is zero and how well a
// 2-bit saturating counter predicts it.
// ----------------------------------------------------------------------------
// Each input transfer carries one observed load value; the entry at
// base_index + offset is read, its counters and 2-bit predictor are updated
// and written back, and one result transfer reports the prediction and the
// updated counts. A base_index of -1 is consumed with no result. An entry
// index outside the table returns status 1 and changes nothing. Each item
// passes through a memory read, then update/write-back; the next item is
// taken only after the previous write-back, which keeps back-to-back hits
// on one entry coherent without forwarding. The result sits in an output
// register, so a stalled m_tready holds the update state but the input side
// is free once the result is loaded. After reset the table is swept to its
// reset values, one entry per cycle; s_tready stays low until the sweep is
// done.
// ----------------------------------------------------------------------------
module zero_value_predictor_table_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, low bit up: value[63:0], base_index[76:64], offset[88:77], zero fill
    input  logic [zvpt_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: value_kind[1:0]
    input  logic [zvpt_pkg::KIND_W-1:0]   s_tuser,
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, low bit up: entry_index[11:0], was_zero[12], predicted_zero[13],
    // prediction_hit[14], total_seen[46:15], zeros_seen[78:47],
    // hits_seen[110:79], zero fill
    output logic [zvpt_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: status[0]
    output logic                          m_tuser
);

    import zvpt_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // ---------------- input unpack ----------------
    logic [VALUE_W-1:0]  in_value;
    logic [BASE_W-1:0]   in_base;
    logic [OFFSET_W-1:0] in_offset;
    logic signed [SUM_W-1:0] in_sum;
    logic [31:0]         in_sum_ext;
    logic                in_skip;
    logic                in_oob;
    logic                s_xfer;

    assign in_value  = s_tdata[63:0];
    assign in_base   = s_tdata[76:64];
    assign in_offset = s_tdata[88:77];

    // Signed base plus unsigned offset
    assign in_sum     = $signed({in_base[BASE_W-1], in_base})
                      + $signed({2'b00, in_offset});
    assign in_sum_ext = 32'(in_sum[SUM_W-2:0]);
    assign in_skip    = (in_base == BASE_SKIP);
    assign in_oob     = in_sum[SUM_W-1] || (in_sum_ext >= 32'(TABLE_DEPTH));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // ---------------- item registers (read cycle) ----------------
    logic [ADDR_W-1:0]  addr_reg;
    logic [ENTRY_W-1:0] idx_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic               zero_reg;
    logic               oob_reg;

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            addr_reg <= in_sum_ext[ADDR_W-1:0];
            idx_reg  <= in_sum_ext[ENTRY_W-1:0];
            kind_reg <= s_tuser;
            zero_reg <= tests_zero(in_value, s_tuser);
            oob_reg  <= in_oob;
        end
    end

    // ---------------- table memory ----------------
    logic [CLR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    entry_t            ram_rdata;
    logic              out_free;
    logic              upd_fire;
    entry_t            upd_entry;

    zvpt_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_xfer),
        .raddr (in_sum_ext[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- update ----------------
    logic pred_zero;
    logic hit;

    assign out_free = !m_tvalid || m_tready;
    assign upd_fire = (state_reg == ST_UPDATE) && out_free;

    assign pred_zero = !ram_rdata.pred[1];
    assign hit       = (pred_zero == zero_reg);

    always_comb begin
        upd_entry      = ram_rdata;
        upd_entry.kind = kind_reg;
        upd_entry.total = sat_inc(ram_rdata.total);
        if (zero_reg) begin
            upd_entry.zeros = sat_inc(ram_rdata.zeros);
            upd_entry.pred  = (ram_rdata.pred <= 2'd1) ? 2'd0 : ram_rdata.pred - 2'd1;
        end else begin
            upd_entry.pred  = (ram_rdata.pred >= 2'd2) ? 2'd3 : ram_rdata.pred + 2'd1;
        end
        if (hit) begin
            upd_entry.hits = sat_inc(ram_rdata.hits);
        end
    end

    // Write port: clearing sweep after reset, then write-back of updates
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg[ADDR_W-1:0];
            ram_wdata = ENTRY_RESET;
        end else begin
            ram_we    = upd_fire && !oob_reg;
            ram_waddr = addr_reg;
            ram_wdata = upd_entry;
        end
    end

    // ---------------- control ----------------
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                if (clr_cnt_reg == CLR_W'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // Skip items are consumed here with no result
                if (s_xfer && !in_skip) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ---------------- output register ----------------
    logic                 m_valid_reg;
    logic [ENTRY_W-1:0]   o_idx_reg;
    logic                 o_status_reg;
    logic                 o_zero_reg;
    logic                 o_pred_reg;
    logic                 o_hit_reg;
    logic [OUT_CNT_W-1:0] o_total_reg;
    logic [OUT_CNT_W-1:0] o_zeros_reg;
    logic [OUT_CNT_W-1:0] o_hits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (upd_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_fire) begin
            o_zero_reg <= zero_reg;
            if (oob_reg) begin
                // Out-of-table item: status reads range, every data field but was_zero reads zero
                o_idx_reg    <= '0;
                o_status_reg <= STATUS_RANGE;
                o_pred_reg   <= 1'b0;
                o_hit_reg    <= 1'b0;
                o_total_reg  <= '0;
                o_zeros_reg  <= '0;
                o_hits_reg   <= '0;
            end else begin
                o_idx_reg    <= idx_reg;
                o_status_reg <= STATUS_OK;
                o_pred_reg   <= pred_zero;
                o_hit_reg    <= hit;
                o_total_reg  <= out_count(upd_entry.total);
                o_zeros_reg  <= out_count(upd_entry.zeros);
                o_hits_reg   <= out_count(upd_entry.hits);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {1'b0, o_hits_reg, o_zeros_reg, o_total_reg,
                       o_hit_reg, o_pred_reg, o_zero_reg, o_idx_reg};

endmodule

// File: rtl/zvpt_ram.sv
// ----------------------------------------------------------------------------
// zvpt_ram - simple dual-port table memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module zvpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/zvpt_chk.sv
// ----------------------------------------------------------------------------
// zvpt_chk - port-level checker for the zero value predictor table
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module zvpt_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [zvpt_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [zvpt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    import zvpt_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A table item occupies the block: no new transfer in the next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[76:64] != BASE_SKIP) |=> !s_tready)
        else $error("input taken during update");

    // Updated entry has counted at least this observation
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_OK) |->
            (m_tdata[46:15] != '0) && (m_tdata[78:47] <= m_tdata[46:15])
            && (m_tdata[110:79] <= m_tdata[46:15]))
        else $error("inconsistent counts");

    // Out-of-table result carries only was_zero
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_RANGE) |->
            (m_tdata[11:0] == '0) && (m_tdata[110:13] == '0))
        else $error("out-of-table result not cleared");

endmodule

bind zero_value_predictor_table_core zvpt_chk u_zvpt_chk (.*);

// File: bench/zero_value_predictor_table_core_tb.sv
// ----------------------------------------------------------------------------
// zero_value_predictor_table_core_tb - self-checking bench for the predictor table
// Streams load observations into the table and compares every result transfer
// against a local model of the per-entry counters and 2-bit predictors.
// ----------------------------------------------------------------------------
// Directed tests cover the zero test of each value kind, skip items, indexes
// outside the table and a full walk of one predictor. Random traffic follows,
// mostly aimed at a few hot entries so counters and predictors move a lot,
// split by a pause that waits for every outstanding result. The sender works
// in bursts with random gaps; the receiver stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module zero_value_predictor_table_core_tb;
    import zvpt_pkg::*;

    // The cycle limit covers the sweep after reset and the rest of the run,
    // even with the slowest receiver pattern.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;

    // Expected content of one result transfer
    typedef struct packed {
        logic [ENTRY_W-1:0]   entry;
        logic                 status;
        logic                 was_zero;
        logic                 pred_zero;
        logic                 hit;
        logic [OUT_CNT_W-1:0] total;
        logic [OUT_CNT_W-1:0] zeros;
        logic [OUT_CNT_W-1:0] hits;
    } zv_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [KIND_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    // Local copy of the table
    logic [1:0]             pred_state [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] seen_total [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] seen_zeros [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] hit_count  [TABLE_DEPTH];

    zv_result_t pending_results[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    // Sender burst/gap bookkeeping
    int burst_left = 0;
    int gap_len    = 0;

    // Receiver stall pattern
    int rx_mode = 0;
    int rx_left = 0;

    zero_value_predictor_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop if the table hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Apply one observation to the local table; returns 0 for a skip item.
    function automatic bit predict_observation(input logic [VALUE_W-1:0] value,
                                               input logic [KIND_W-1:0] kind,
                                               input logic [BASE_W-1:0] base,
                                               input logic [OFFSET_W-1:0] off,
                                               output zv_result_t res);
        int   idx;
        logic zero;
        logic [1:0] st;
        res = '0;
        if (base == BASE_SKIP)
            return 1'b0;
        // floats ignore their sign bit, so both zeros count
        if (kind == KIND_F32)
            zero = ((value & 64'h0000_0000_7FFF_FFFF) == '0);
        else if (kind == KIND_F64)
            zero = ((value << 1) == '0);
        else
            zero = (value == '0);
        res.was_zero = zero;
        idx = int'($signed(base)) + int'(off);
        if (idx < 0 || idx >= TABLE_DEPTH) begin
            res.status = STATUS_RANGE;
            return 1'b1;
        end
        st            = pred_state[idx];
        res.status    = STATUS_OK;
        res.entry     = ENTRY_W'(idx);
        res.pred_zero = (st < 2);
        res.hit       = (res.pred_zero == zero);
        if (seen_total[idx] != '1)
            seen_total[idx] = seen_total[idx] + 1'b1;
        if (zero && seen_zeros[idx] != '1)
            seen_zeros[idx] = seen_zeros[idx] + 1'b1;
        if (res.hit && hit_count[idx] != '1)
            hit_count[idx] = hit_count[idx] + 1'b1;
        // 2-bit saturating walk toward the observed class
        if (zero)
            pred_state[idx] = (st == 2'd0) ? 2'd0 : st - 2'd1;
        else
            pred_state[idx] = (st == 2'd3) ? 2'd3 : st + 2'd1;
        res.total = OUT_CNT_W'(seen_total[idx]);
        res.zeros = OUT_CNT_W'(seen_zeros[idx]);
        res.hits  = OUT_CNT_W'(hit_count[idx]);
        return 1'b1;
    endfunction

    // Drive one observation and hold it until the transfer happens.
    task automatic send_observation(input logic [VALUE_W-1:0] value,
                                    input logic [KIND_W-1:0] kind,
                                    input logic [BASE_W-1:0] base,
                                    input logic [OFFSET_W-1:0] off);
        zv_result_t res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, off, base, value};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        if (predict_observation(value, kind, base, off, res))
            pending_results.push_back(res);
    endtask

    // Idle the sender until every outstanding result has been taken.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [OUT_CNT_W-1:0] want,
                               input logic [OUT_CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: switches among random stall modes
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(5, 60);
            end else begin
                rx_left = rx_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;                           // no back-pressure
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) == 0);    // heavy stall
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    // Result checker: every transfer against the oldest expectation
    always @(posedge aclk) begin : result_check
        zv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: m_tdata=0x%0h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",         OUT_CNT_W'(want.status),
                            OUT_CNT_W'(m_tuser));
                check_field("entry_index",    OUT_CNT_W'(want.entry),
                            OUT_CNT_W'(m_tdata[11:0]));
                check_field("was_zero",       OUT_CNT_W'(want.was_zero),
                            OUT_CNT_W'(m_tdata[12]));
                check_field("predicted_zero", OUT_CNT_W'(want.pred_zero),
                            OUT_CNT_W'(m_tdata[13]));
                check_field("prediction_hit", OUT_CNT_W'(want.hit),
                            OUT_CNT_W'(m_tdata[14]));
                check_field("total_seen",     want.total,     m_tdata[46:15]);
                check_field("zeros_seen",     want.zeros,     m_tdata[78:47]);
                check_field("hits_seen",      want.hits,      m_tdata[110:79]);
            end
        end
    end

    // Zero test of each kind: sign bits ignored for floats only
    task automatic test_value_kinds();
        send_observation(64'h0,                   KIND_INT,     13'd10, 12'd0);
        send_observation(64'hFFFF_FFFF_FFFF_FFFF, KIND_INT,     13'd10, 12'd1);
        send_observation(64'h0000_0000_8000_0000, KIND_F32,     13'd10, 12'd2);
        send_observation(64'hFFFF_FFFF_0000_0000, KIND_F32,     13'd10, 12'd3);
        send_observation(64'h0000_0000_0000_0001, KIND_F32,     13'd10, 12'd4);
        send_observation(64'h8000_0000_0000_0000, KIND_F64,     13'd10, 12'd5);
        send_observation(64'h0000_0000_8000_0000, KIND_F64,     13'd10, 12'd6);
        send_observation(64'h0,                   KIND_UNKNOWN, 13'd10, 12'd7);
        send_observation(64'h8000_0000_0000_0000, KIND_UNKNOWN, 13'd10, 12'd8);
    endtask

    // Base of -1 is dropped whatever the offset
    task automatic test_skip_items();
        send_observation(64'h0,   KIND_INT, BASE_SKIP, 12'd0);
        send_observation(64'h5,   KIND_F64, BASE_SKIP, 12'd1);
        send_observation(64'h0,   KIND_F32, BASE_SKIP, 12'hFFF);
    endtask

    // Edges of the table and negative bases other than skip
    task automatic test_table_bounds();
        send_observation(64'h7,   KIND_INT, 13'd4095,  12'd1);     // one past the end
        send_observation(64'h0,   KIND_INT, 13'd4095,  12'hFFF);   // largest sum
        send_observation(64'h3,   KIND_INT, 13'h1000,  12'd0);     // most negative base
        send_observation(64'h0,   KIND_INT, 13'h1FFE,  12'd1);     // -2 + 1 = -1
        send_observation(64'h9,   KIND_INT, 13'h1FFE,  12'd2);     // -2 + 2 = entry 0
        send_observation(64'h0,   KIND_INT, 13'd0,     12'hFFF);   // last entry
    endtask

    // Walk one predictor through all four states and back
    task automatic test_predictor_states();
        repeat (4) send_observation(64'h1, KIND_INT, 13'd100, 12'd0);
        repeat (4) send_observation(64'h0, KIND_INT, 13'd100, 12'd0);
    endtask

    // Random observations; count excludes skip items
    task automatic test_random_traffic(input int count);
        int               sent;
        int               sel;
        int               b;
        int               hot;
        logic [VALUE_W-1:0]  value;
        logic [KIND_W-1:0]   kind;
        logic [BASE_W-1:0]   base;
        logic [OFFSET_W-1:0] off;
        int               hot_entry [8];
        for (int i = 0; i < 8; i++)
            hot_entry[i] = $urandom_range(0, TABLE_DEPTH - 1);
        hot_entry[0] = 0;
        hot_entry[1] = TABLE_DEPTH - 1;
        sent = 0;
        while (sent < count) begin
            sel = $urandom_range(0, 9);
            kind = (sel < 4) ? KIND_INT : (sel < 7) ? KIND_F32 :
                   (sel < 9) ? KIND_F64 : KIND_UNKNOWN;
            // zero-like patterns are common so predictors move both ways
            case ($urandom_range(0, 7)) inside
                [0:1]: value = '0;
                2: value = 64'h8000_0000_0000_0000;
                3: value = 64'h0000_0000_8000_0000;
                4: value = {$urandom, 32'h0} | (($urandom_range(0, 1)) ? 64'h8000_0000 : 64'h0);
                5: value = 64'h1 << $urandom_range(0, 63);
                default: value = {$urandom, $urandom};
            endcase
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                hot  = hot_entry[$urandom_range(0, 7)];
                b    = $urandom_range(0, hot);
                base = BASE_W'(b);
                off  = OFFSET_W'(hot - b);
            end else if (sel < 80) begin
                b    = $urandom_range(0, TABLE_DEPTH - 1);
                base = BASE_W'(b);
                off  = OFFSET_W'($urandom_range(0, TABLE_DEPTH - 1 - b));
            end else if (sel < 90) begin
                base = BASE_W'($urandom_range(0, 8191));
                off  = OFFSET_W'($urandom_range(0, 4095));
            end else if (sel < 95) begin
                base = BASE_SKIP;
                off  = OFFSET_W'($urandom_range(0, 4095));
            end else begin
                base = BASE_W'(-int'($urandom_range(2, 4096)));
                off  = OFFSET_W'($urandom_range(0, 15));
            end
            send_observation(value, kind, base, off);
            if (base != BASE_SKIP)
                sent++;
        end
    endtask

    // Full drain, then a tight burst on one entry from an empty pipeline
    task automatic test_drain_then_burst();
        wait_for_results();
        for (int i = 0; i < 12; i++)
            send_observation((i % 3 == 0) ? 64'h0 : 64'h42, KIND_INT, 13'd200, 12'd7);
    endtask

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            pred_state[i] = '0;
            seen_total[i] = '0;
            seen_zeros[i] = '0;
            hit_count[i]  = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_value_kinds();
        test_skip_items();
        test_table_bounds();
        test_predictor_states();
        test_random_traffic(900);
        test_drain_then_burst();
        test_random_traffic(900);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
